// ----- hw/rtl/pcir_pkg.sv -----
// pcir_pkg: shared widths and controller/datapath command and status types
// for the prime counting block; depends on nothing
package pcir_pkg;

    localparam int VALUE_BITS = 16;
    localparam int IN_W       = 16;
    localparam int COUNT_W    = 16;
    localparam int VAL_W      = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
    localparam int SQ_W       = VAL_W + 2;
    localparam int BIT_CNT_W  = (VAL_W > 1) ? $clog2(VAL_W) : 1;

    typedef struct packed {
        logic load;
        logic start_v;
        logic div_start;
        logic div_step;
        logic next_d;
        logic count_inc;
        logic next_v;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic v_small;
        logic sq_over;
        logic div_last;
        logic rem_zero;
        logic v_last;
    } t_status;

endpackage

// ----- hw/rtl/pcir_in_if.sv -----
// pcir_in_if: input channel carrying one range per beat
// depends on pcir_pkg for the field width
interface pcir_in_if;
    logic                      valid;
    logic                      ready;
    logic [pcir_pkg::IN_W-1:0] range_low;
    logic [pcir_pkg::IN_W-1:0] range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

// ----- hw/rtl/pcir_out_if.sv -----
// pcir_out_if: output channel carrying one prime count per beat
// depends on pcir_pkg for the field width
interface pcir_out_if;
    logic                         valid;
    logic                         ready;
    logic [pcir_pkg::COUNT_W-1:0] prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

// ----- hw/rtl/pcir_dp.sv -----
// pcir_dp: datapath with range bounds, candidate and divisor registers,
// bit-serial remainder unit, prime counter and output register; uses pcir_pkg
module pcir_dp (
    input  logic                         i_clk,
    input  logic [pcir_pkg::IN_W-1:0]    i_range_low,
    input  logic [pcir_pkg::IN_W-1:0]    i_range_high,
    input  pcir_pkg::t_cmd               i_cmd,
    output pcir_pkg::t_status            o_status,
    output logic [pcir_pkg::COUNT_W-1:0] o_prime_count
);

    localparam int VW = pcir_pkg::VAL_W;
    localparam int SW = pcir_pkg::SQ_W;
    localparam int CW = pcir_pkg::COUNT_W;
    localparam int BW = pcir_pkg::BIT_CNT_W;

    logic [VW-1:0] r_lo, r_hi, r_v, r_d, r_rem, r_sh;
    logic [SW-1:0] r_dsq;
    logic [BW-1:0] r_bit;
    logic [CW-1:0] r_count, r_out;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic [VW-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_sh[VW-1]};
        diff    = shifted - {1'b0, r_d};
        if (shifted >= {1'b0, r_d}) begin
            n_rem = diff[VW-1:0];
        end else begin
            n_rem = shifted[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo    <= i_range_low[VW-1:0];
            r_hi    <= i_range_high[VW-1:0];
            r_v     <= i_range_low[VW-1:0];
            r_count <= '0;
        end
        if (i_cmd.start_v) begin
            r_d   <= VW'(2);
            r_dsq <= SW'(4);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_sh  <= r_v;
            r_bit <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[VW-2:0], 1'b0};
            r_bit <= r_bit + BW'(1);
        end
        if (i_cmd.next_d) begin
            r_d   <= r_d + VW'(1);
            r_dsq <= r_dsq + {1'b0, r_d, 1'b1};
        end
        if (i_cmd.count_inc && (r_count != {CW{1'b1}})) begin
            r_count <= r_count + CW'(1);
        end
        if (i_cmd.next_v) begin
            r_v <= r_v + VW'(1);
        end
        if (i_cmd.publish) begin
            r_out <= r_count;
        end
    end

    assign o_status.empty    = r_lo > r_hi;
    assign o_status.v_small  = r_v < VW'(2);
    assign o_status.sq_over  = r_dsq > {2'b00, r_v};
    assign o_status.div_last = r_bit == BW'(VW - 1);
    assign o_status.rem_zero = r_rem == '0;
    assign o_status.v_last   = r_v == r_hi;
    assign o_prime_count     = r_out;

endmodule

// ----- hw/rtl/pcir_ctrl.sv -----
// pcir_ctrl: controller state machine sequencing candidates, divisors and
// remainder steps, and owning both channel handshakes; uses pcir_pkg
module pcir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pcir_pkg::t_status i_status,
    output pcir_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_VAL, S_TEST, S_DIV, S_REM, S_ADV, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   out_free;

    assign out_free   = !o_out_valid || i_out_ready;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = i_status.empty ? S_FIN : S_VAL;
            end
            S_VAL: begin
                if (i_status.v_small) begin
                    n_state = S_ADV;
                end else begin
                    o_cmd.start_v = 1'b1;
                    n_state       = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.sq_over) begin
                    o_cmd.count_inc = 1'b1;
                    n_state         = S_ADV;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                if (i_status.rem_zero) begin
                    n_state = S_ADV;
                end else begin
                    o_cmd.next_d = 1'b1;
                    n_state      = S_TEST;
                end
            end
            S_ADV: begin
                if (i_status.v_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.next_v = 1'b1;
                    n_state      = S_VAL;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.publish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/prime_count_in_range_core.sv -----
// prime_count_in_range_core: counts primes in an inclusive range by trial division
// Depends on pcir_pkg, pcir_in_if, pcir_out_if, pcir_ctrl and pcir_dp.
// One range is worked at a time; the input is ready only while the block is idle, and the
// result sits in an output register so a new range is taken while it waits. Each candidate
// is tested against every trial divisor up to its square root in the one bit-serial
// remainder unit, which sets the rate.
module prime_count_in_range_core (
    input  logic i_clk,
    input  logic i_rst_n,
    pcir_in_if.sink    i_in,
    pcir_out_if.source o_out
);

    pcir_pkg::t_cmd    cmd;
    pcir_pkg::t_status status;

    pcir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pcir_dp u_dp (
        .i_clk         (i_clk),
        .i_range_low   (i_in.range_low),
        .i_range_high  (i_in.range_high),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_prime_count (o_out.prime_count)
    );

endmodule

// ----- hw/rtl/pcir_chk.sv -----
// pcir_chk: port-level checks for prime_count_in_range_core, bound to the top
// depends on pcir_pkg for widths
module pcir_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic [pcir_pkg::IN_W-1:0]    i_range_low,
    input logic [pcir_pkg::IN_W-1:0]    i_range_high,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pcir_pkg::COUNT_W-1:0] i_prime_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_prime_count))
        else $error("stalled result beat changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("channels not quiet after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second range taken while one is in work");

    a_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid
            && (i_range_low[pcir_pkg::VAL_W-1:0] > i_range_high[pcir_pkg::VAL_W-1:0])
        |-> ##3 i_out_valid && (i_prime_count == '0))
        else $error("empty range did not give a zero count");

endmodule

bind prime_count_in_range_core pcir_chk u_pcir_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_range_low   (i_in.range_low),
    .i_range_high  (i_in.range_high),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_prime_count (o_out.prime_count)
);
